@@ src/tks_pkg.sv @@
package tks_pkg;

	localparam int SCORE_W = 32;
	localparam int IDX_W   = 12;
	localparam int TOPK_W  = 4;
	localparam int DATA_W  = 32;
	localparam int ADDR_W  = 3;
	localparam int RIDX_W  = ADDR_W - 2;

	// register index, one word per register
	localparam logic [RIDX_W-1:0] REG_TOP_K = RIDX_W'(0);

	localparam logic [TOPK_W-1:0] TOP_K_RESET = TOPK_W'(1);

	typedef logic signed [SCORE_W-1:0] score_t;
	typedef logic [IDX_W-1:0]          class_idx_t;

	typedef struct packed {
		score_t     score;
		class_idx_t idx;
	} entry_t;

endpackage

@@ src/tks_if.sv @@
interface tks_score_if;
	import tks_pkg::*;

	logic   valid;
	logic   ready;
	score_t score;
	logic   last;

	modport source (output valid, output score, output last, input ready);
	modport sink (input valid, input score, input last, output ready);
endinterface

interface tks_rank_if;
	import tks_pkg::*;

	logic       valid;
	logic       ready;
	class_idx_t class_index;
	score_t     class_score;
	logic       final_result;

	modport source (output valid, output class_index, output class_score,
		output final_result, input ready);
	modport sink (input valid, input class_index, input class_score,
		input final_result, output ready);
endinterface

@@ src/tks_insert.sv @@
module tks_insert #(
	parameter int MAX_K = 8,
	localparam int KW = $clog2(MAX_K + 1)
) (
	input  tks_pkg::entry_t [MAX_K-1:0] store,
	input  logic [KW-1:0]               filled,
	input  tks_pkg::entry_t             item,
	output tks_pkg::entry_t [MAX_K-1:0] next_store,
	output logic [KW-1:0]               next_filled
);
	import tks_pkg::*;

	logic [MAX_K-1:0] ge;
	logic [MAX_K-1:0] ge_ext;
	entry_t [MAX_K-1:0] shifted;

	// stored entries at or above the new score form a prefix of the ranking
	always_comb begin
		for (int i = 0; i < MAX_K; i++) begin
			ge[i] = (KW'(i) < filled) && (store[i].score >= item.score);
		end
		ge_ext = MAX_K'({ge, 1'b1});
		shifted[0] = item;
		for (int i = 1; i < MAX_K; i++) begin
			shifted[i] = store[i-1];
		end
		for (int i = 0; i < MAX_K; i++) begin
			if (ge[i]) begin
				next_store[i] = store[i];
			end else if (ge_ext[i]) begin
				next_store[i] = item;
			end else begin
				next_store[i] = shifted[i];
			end
		end
		next_filled = (filled < KW'(MAX_K)) ? filled + KW'(1) : filled;
	end

endmodule

@@ src/top_k_score_select.sv @@
// Channel   Dir  Payload                                   Role
// scores    in   score, last                               class scores in class order
// ranks     out  class_index, class_score, final_result    best K classes, best first
// APB       cfg  top_k at byte address 0                   requested K
//
// One score is taken per cycle unless a held last item stalls the input. It is
// held in the input register and ranked against all kept entries at once on leaving.
// A last item copies the ranking into the result queue; up to K results then leave
// one per cycle while ranks.ready holds. A further last item waits in the input
// register until the queue drains, stalling scores; other scores flow meanwhile.
// arst_n clears control state and sets top_k to 1; the ranking store has no reset.
module top_k_score_select #(
	parameter int MAX_K       = 8,
	parameter int MAX_CLASSES = 4096
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tks_pkg::ADDR_W-1:0]  paddr,
	input  logic [tks_pkg::DATA_W-1:0]  pwdata,
	output logic [tks_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	tks_score_if.sink                   scores,
	tks_rank_if.source                  ranks
);
	import tks_pkg::*;

	localparam int KW   = $clog2(MAX_K + 1);
	localparam int CW   = $clog2(MAX_CLASSES + 1);
	localparam int CMPW = (KW > TOPK_W) ? KW : TOPK_W;

	// configuration
	logic [TOPK_W-1:0] top_k_q;
	logic [RIDX_W-1:0] reg_idx;
	logic              cfg_wr;

	// input stage
	logic       valid_s1;
	logic       last_s1;
	logic       keep_s1;     // class index lies within MAX_CLASSES
	entry_t     item_s1;
	logic [CW-1:0] cnt_q;
	logic       in_acc;
	logic       adv;

	// ranking store
	entry_t [MAX_K-1:0] store_q;
	entry_t [MAX_K-1:0] store_nx;
	logic [KW-1:0]      filled_q;
	logic [KW-1:0]      filled_nx;

	// result queue
	entry_t [MAX_K-1:0] emit_q;
	logic [KW-1:0]      rem_q;
	logic               out_acc;
	logic               emit_free;
	logic               load;

	// effective K
	logic [TOPK_W-1:0] k_req;
	logic [KW-1:0]     k_cap;
	logic [KW-1:0]     k_eff;

	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign cfg_wr  = psel & penable & pwrite;

	always_comb begin
		unique case (reg_idx)
			REG_TOP_K: prdata = DATA_W'(top_k_q);
			default:   prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_k_q <= TOP_K_RESET;
		end else if (cfg_wr && reg_idx == REG_TOP_K) begin
			top_k_q <= pwdata[TOPK_W-1:0];
		end
	end

	// a last item may only move on once the queue has room for its ranking
	assign out_acc   = ranks.valid & ranks.ready;
	assign emit_free = (rem_q == '0) || (rem_q == KW'(1) && ranks.ready);
	assign adv       = !valid_s1 || !last_s1 || emit_free;
	assign scores.ready = adv;
	assign in_acc    = scores.valid & scores.ready;
	assign load      = valid_s1 & last_s1 & adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (adv) begin
				valid_s1 <= in_acc;
			end
			if (in_acc) begin
				if (scores.last) begin
					cnt_q <= '0;
				end else if (cnt_q < CW'(MAX_CLASSES)) begin
					cnt_q <= cnt_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			last_s1       <= scores.last;
			keep_s1       <= cnt_q < CW'(MAX_CLASSES);
			item_s1.score <= scores.score;
			item_s1.idx   <= IDX_W'(cnt_q);
		end
	end

	tks_insert #(.MAX_K(MAX_K)) u_insert (
		.store       (store_q),
		.filled      (filled_q),
		.item        (item_s1),
		.next_store  (store_nx),
		.next_filled (filled_nx)
	);

	// ranking including the item in the input register
	entry_t [MAX_K-1:0] rank_now;
	logic [KW-1:0]      fill_now;

	assign rank_now = keep_s1 ? store_nx : store_q;
	assign fill_now = keep_s1 ? filled_nx : filled_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filled_q <= '0;
		end else if (valid_s1 && adv) begin
			filled_q <= last_s1 ? '0 : fill_now;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv) begin
			store_q <= rank_now;
		end
	end

	// top_k of zero means one, then clamp to MAX_K and to what is kept
	always_comb begin
		k_req = (top_k_q == '0) ? TOPK_W'(1) : top_k_q;
		if (CMPW'(k_req) > CMPW'(MAX_K)) begin
			k_cap = KW'(MAX_K);
		end else begin
			k_cap = KW'(k_req);
		end
		k_eff = (k_cap < fill_now) ? k_cap : fill_now;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (load) begin
			rem_q <= k_eff;
		end else if (out_acc) begin
			rem_q <= rem_q - KW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			emit_q <= rank_now;
		end else if (out_acc) begin
			for (int i = 0; i < MAX_K - 1; i++) begin
				emit_q[i] <= emit_q[i+1];
			end
		end
	end

	assign ranks.valid        = rem_q != '0;
	assign ranks.class_index  = emit_q[0].idx;
	assign ranks.class_score  = emit_q[0].score;
	assign ranks.final_result = rem_q == KW'(1);

`ifndef SYNTHESIS
	a_filled_bound: assert property (@(posedge clk) disable iff (!arst_n)
		filled_q <= KW'(MAX_K))
		else $error("ranking store over-filled");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_CLASSES))
		else $error("class counter past MAX_CLASSES");

	a_load_emits: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> ranks.valid && filled_q == '0)
		else $error("last item gave no result or left the store filled");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && !ranks.final_result |=> ranks.valid)
		else $error("ranked run broke off before its final result");

	a_queue_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q >= KW'(2) |-> emit_q[0].score >= emit_q[1].score)
		else $error("results leave out of rank order");
`endif

endmodule
